// File: rtl/kps_pkg.sv
// Shared widths, codes and the status type for the keyed permutation shuffle unit.
`timescale 1ns / 1ps
`default_nettype none

package kps_pkg;

  // Entry and key byte width, and the width of a two-byte key sum
  localparam int DATA_W = 8;
  localparam int SUM_W  = DATA_W + 1;
  localparam int BIT_W  = $clog2(SUM_W);

  // Store depth default and register reset value
  localparam int              MAX_ENTRIES_DEF = 256;
  localparam logic [DATA_W-1:0] TOP_RESET     = 8'hFF;

  // Item mode codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Status of the remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } kps_mod_stat_t;

endpackage

`default_nettype wire

// File: rtl/kps_mod_unit.sv
// Bit-serial remainder unit: one quotient bit per cycle over the key sum.
`timescale 1ns / 1ps
`default_nettype none

module kps_mod_unit
  import kps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output kps_mod_stat_t          stat,
  output logic      [DATA_W-1:0] remainder
);

  logic              run_r;
  logic              done_r;
  logic [BIT_W-1:0]  bit_r;
  logic [SUM_W-1:0]  sum_r;
  logic [DATA_W-1:0] dv_r;
  logic [DATA_W-1:0] rem_r;
  logic [SUM_W-1:0]  trial;
  logic [SUM_W-1:0]  diff;
  logic [DATA_W-1:0] rem_nxt;

  // Shift in the next dividend bit and subtract when the divisor fits
  always_comb begin
    trial   = {rem_r, sum_r[bit_r]};
    diff    = trial - {1'b0, dv_r};
    rem_nxt = (trial >= {1'b0, dv_r}) ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
  end

  // Run from the top dividend bit down to bit zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        bit_r <= BIT_W'(SUM_W - 1);
        sum_r <= dividend;
        dv_r  <= divisor;
        rem_r <= '0;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        if (bit_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          bit_r <= bit_r - BIT_W'(1);
        end
      end
    end
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// File: rtl/keyed_permutation_shuffle_unit.sv
// Top level: key load, keyed Sattolo-style shuffle sequencer and permutation reads.
//
// Usage. An item is taken when start is high and busy is low. With in_mode at
// load, in_key_byte is appended to the key; with in_mode at read, the entry at
// in_position is returned on out_entry_value with out_complete, marked by a
// one-cycle out_valid beat. Load beats give no result.
// The key holds top_index+1 bytes (top_index saturated to min(MAX_ENTRIES,256)-1). Its
// first byte puts the permutation back to the identity; its last byte starts
// the shuffle, which walks i from top_index down to 1 and swaps entries i and
// (key[i-1] + key[i]) mod i.
// A load that is not the last byte leaves busy low. A read holds busy in S_RD,
// where the registered store read returns, and its result is registered there.
// The last key byte holds busy through every swap step: S_KEY and S_SUM read
// the key store, S_DIV waits on the bit-serial remainder unit, and S_RDI, S_RDJ,
// S_WRI and S_WRJ do the two reads and two writes of the permutation store.
// Reset restores top_index to 255, clears the key count and the completion
// flag, and marks the whole permutation store as identity at once.
// The receiver cannot stall: each result beat is valid for one cycle only.
// cfg_we is to write top_index only while idle; the block does not enforce it.
// A write through cfg_we drops any partial key.
`timescale 1ns / 1ps
`default_nettype none

module keyed_permutation_shuffle_unit
  import kps_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_mode,
  input  wire logic [DATA_W-1:0] in_key_byte,
  input  wire logic [DATA_W-1:0] in_position,
  output logic                   out_valid,
  output logic      [DATA_W-1:0] out_entry_value,
  output logic                   out_complete,
  input  wire logic              cfg_we,
  input  wire logic [DATA_W-1:0] cfg_wdata
);

  // Only entries below DEPTH, which is MAX_ENTRIES capped at 256, can be touched or addressed
  localparam int DEPTH   = (MAX_ENTRIES < 256) ? MAX_ENTRIES : 256;
  localparam int AW      = $clog2(DEPTH);
  localparam int TOP_LIM = DEPTH - 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_KEY, S_SUM, S_DIV, S_RDI, S_RDJ, S_WRI, S_WRJ
  } state_t;

  function automatic logic [AW-1:0] to_addr(input logic [DATA_W-1:0] x);
    logic [AW+DATA_W-1:0] w;
    w = {{AW{1'b0}}, x};
    return w[AW-1:0];
  endfunction

  state_t            state_r;
  logic [DATA_W-1:0] top_r;
  logic [DATA_W-1:0] cnt_r;
  logic              done_r;
  logic [DATA_W-1:0] i_r;
  logic [DATA_W-1:0] j_r;
  logic [DATA_W-1:0] key_hi_r;
  logic [DATA_W-1:0] vi_r;
  logic              rd_ok_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_complete_r;

  logic [DATA_W-1:0] n_eff;
  logic              accept;
  logic              pos_ok;

  // Store controls
  logic              perm_we;
  logic [AW-1:0]     perm_wa;
  logic [DATA_W-1:0] perm_wd;
  logic [AW-1:0]     perm_ra;
  logic              vld_clr;
  logic              key_we;
  logic [AW-1:0]     key_wa;
  logic [AW-1:0]     key_ra;

  // Stores
  logic [DATA_W-1:0] perm_mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] perm_q_r;
  logic              perm_qv_r;
  logic [AW-1:0]     perm_qa_r;
  logic [DATA_W-1:0] perm_val;
  logic [AW+DATA_W-1:0] ident_w;
  logic [DATA_W-1:0] key_mem [DEPTH];
  logic [DATA_W-1:0] key_q_r;

  // Remainder unit
  kps_mod_stat_t     mod_stat;
  logic [DATA_W-1:0] mod_rem;
  logic              mod_start;
  logic [SUM_W-1:0]  mod_sum;

  // Saturate the top index and qualify the read position
  always_comb begin
    n_eff  = (top_r > DATA_W'(TOP_LIM)) ? DATA_W'(TOP_LIM) : top_r;
    pos_ok = (in_position <= DATA_W'(TOP_LIM));
    accept = start && (state_r == S_IDLE);
  end

  // Entries never written since the last clear read as their own index
  always_comb begin
    ident_w  = {{DATA_W{1'b0}}, perm_qa_r};
    perm_val = perm_qv_r ? perm_q_r : ident_w[DATA_W-1:0];
    mod_sum  = {1'b0, key_hi_r} + {1'b0, key_q_r};
  end

  // Drive store ports from the sequencer state
  always_comb begin
    perm_we   = 1'b0;
    perm_wa   = to_addr(i_r);
    perm_wd   = perm_val;
    perm_ra   = to_addr(in_position);
    vld_clr   = 1'b0;
    key_we    = 1'b0;
    key_wa    = to_addr(cnt_r);
    key_ra    = to_addr(i_r - DATA_W'(1));
    mod_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_mode == MODE_LOAD) begin
          key_we  = 1'b1;
          vld_clr = (cnt_r == '0);
        end
      end
      S_SUM:   mod_start = 1'b1;
      S_RDI:   perm_ra = to_addr(i_r);
      S_RDJ:   perm_ra = to_addr(j_r);
      S_WRI: begin
        perm_we = 1'b1;
        perm_wa = to_addr(i_r);
        perm_wd = perm_val;
      end
      S_WRJ: begin
        perm_we = 1'b1;
        perm_wa = to_addr(j_r);
        perm_wd = vi_r;
      end
      default: ;
    endcase
  end

  // Permutation store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_wa] <= perm_wd;
    end
    perm_q_r  <= perm_mem[perm_ra];
    perm_qa_r <= perm_ra;
    perm_qv_r <= vld_r[perm_ra];
  end

  // Written marks: clear all at reset and at the first byte of a key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (vld_clr) begin
      vld_r <= '0;
    end else if (perm_we) begin
      vld_r[perm_wa] <= 1'b1;
    end
  end

  // Key store
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= in_key_byte;
    end
    key_q_r <= key_mem[key_ra];
  end

  kps_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_sum),
    .divisor   (i_r),
    .stat      (mod_stat),
    .remainder (mod_rem)
  );

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= TOP_RESET;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        top_r  <= cfg_wdata;
        cnt_r  <= '0;
        done_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_mode == MODE_READ) begin
              rd_ok_r <= pos_ok;
              state_r <= S_RD;
            end else begin
              if (cnt_r == '0) begin
                done_r <= 1'b0;
              end
              if (cnt_r == n_eff) begin
                cnt_r <= '0;
                if (n_eff == '0) begin
                  done_r <= 1'b1;
                end else begin
                  i_r      <= n_eff;
                  key_hi_r <= in_key_byte;
                  state_r  <= S_KEY;
                end
              end else begin
                cnt_r <= cnt_r + DATA_W'(1);
              end
            end
          end
        end
        S_RD: begin
          out_valid_r    <= 1'b1;
          out_value_r    <= rd_ok_r ? perm_val : '0;
          out_complete_r <= done_r;
          state_r        <= S_IDLE;
        end
        S_KEY: state_r <= S_SUM;
        S_SUM: begin
          // key[i-1] becomes the upper byte of the next step
          key_hi_r <= key_q_r;
          state_r  <= S_DIV;
        end
        S_DIV: begin
          if (mod_stat.done) begin
            j_r     <= mod_rem;
            state_r <= S_RDI;
          end
        end
        S_RDI: state_r <= S_RDJ;
        S_RDJ: begin
          vi_r    <= perm_val;
          state_r <= S_WRI;
        end
        S_WRI: state_r <= S_WRJ;
        S_WRJ: begin
          if (i_r == DATA_W'(1)) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            i_r     <= i_r - DATA_W'(1);
            state_r <= S_KEY;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_entry_value = out_value_r;
  assign out_complete    = out_complete_r;

  // A result beat follows only the read wait state
  a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_RD))
    else $error("result beat without a read");

  // The swap partner always lies below the loop index
  a_j_below_i: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRJ) |-> (j_r < i_r))
    else $error("swap index out of range");

  // The remainder unit is quiet whenever the block is idle
  a_mod_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mod_stat.busy)
    else $error("remainder unit running while idle");

  // The partial key count stays below the key length
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= n_eff)
    else $error("key count past top index");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the keyed permutation shuffle unit.
`timescale 1ns / 1ps

module tb_top;
  import kps_pkg::*;

  // One expected read beat
  typedef struct {
    logic [DATA_W-1:0] value;
    logic              complete;
  } entry_beat_t;

  // Tracks the permutation, the key and the completion flag; holds pending read beats
  class entry_scoreboard;
    logic [DATA_W-1:0] perm_map [MAX_ENTRIES_DEF];
    logic [DATA_W-1:0] key_bytes [MAX_ENTRIES_DEF];
    int unsigned       key_count;
    logic              done;
    logic [DATA_W-1:0] top;
    entry_beat_t       pending [$];
    int                errors;

    function new();
      errors = 0;
      set_identity();
      foreach (key_bytes[k]) key_bytes[k] = '0;
      key_count = 0;
      done = 1'b0;
      top = TOP_RESET;
    endfunction

    function void set_identity();
      foreach (perm_map[k]) perm_map[k] = DATA_W'(k);
    endfunction

    // Writing the register drops any partial key and clears the flag
    function void write_top(logic [DATA_W-1:0] v);
      top = v;
      key_count = 0;
      done = 1'b0;
    endfunction

    // Effective top index, saturated to one below the store depth
    function int unsigned span();
      int unsigned n;
      n = top;
      if (n > MAX_ENTRIES_DEF - 1) n = MAX_ENTRIES_DEF - 1;
      return n;
    endfunction

    // Walk i down to 1 and swap entries i and (key[i-1] + key[i]) mod i
    function void shuffle(int unsigned n);
      int unsigned i;
      int unsigned j;
      logic [DATA_W-1:0] t;
      for (i = n; i > 0; i--) begin
        j = (int'(key_bytes[i-1]) + int'(key_bytes[i])) % i;
        t = perm_map[i];
        perm_map[i] = perm_map[j];
        perm_map[j] = t;
      end
    endfunction

    // Apply one accepted beat; a read queues its expected result
    function void note_item(logic mode, logic [DATA_W-1:0] kb, logic [DATA_W-1:0] pos);
      int unsigned n;
      entry_beat_t e;
      if (mode == MODE_LOAD) begin
        n = span();
        if (key_count == 0) begin
          set_identity();
          done = 1'b0;
        end
        if (key_count < MAX_ENTRIES_DEF) key_bytes[key_count] = kb;
        key_count++;
        if (key_count >= n + 1) begin
          shuffle(n);
          done = 1'b1;
          key_count = 0;
        end
      end else begin
        if (pos < MAX_ENTRIES_DEF) e.value = perm_map[pos];
        else e.value = '0;
        e.complete = done;
        pending.push_back(e);
      end
    endfunction

    task report(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Compare one result beat with the oldest pending read
    task check_result(logic [DATA_W-1:0] value, logic complete);
      entry_beat_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result beat value=%0d complete=%0b", value, complete));
      end else begin
        e = pending.pop_front();
        if (value !== e.value)
          report($sformatf("entry_value got %0d want %0d", value, e.value));
        if (complete !== e.complete)
          report($sformatf("complete got %0b want %0b", complete, e.complete));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_mode = MODE_LOAD;
  logic [DATA_W-1:0] in_key_byte = '0;
  logic [DATA_W-1:0] in_position = '0;
  logic              out_valid;
  logic [DATA_W-1:0] out_entry_value;
  logic              out_complete;
  logic              cfg_we = 1'b0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  entry_scoreboard sb = new();
  int idle_pct = 0;

  keyed_permutation_shuffle_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_key_byte    (in_key_byte),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_entry_value(out_entry_value),
    .out_complete   (out_complete),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Check every result beat at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_entry_value, out_complete);
  end

  // Offer one beat, with an optional sender gap, and hold it until taken
  task automatic push_item(logic mode, logic [DATA_W-1:0] kb, logic [DATA_W-1:0] pos);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start       <= 1'b1;
    in_mode     <= mode;
    in_key_byte <= kb;
    in_position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(mode, kb, pos);
  endtask

  task automatic load_byte(logic [DATA_W-1:0] kb);
    push_item(MODE_LOAD, kb, DATA_W'($urandom));
  endtask

  task automatic read_entry(logic [DATA_W-1:0] pos);
    push_item(MODE_READ, DATA_W'($urandom), pos);
  endtask

  // Drop start, wait out pending reads and any shuffle in flight
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
    repeat (16 * sb.span() + 16) @(posedge clk);
  endtask

  // Write top_index once the block is idle
  task automatic set_top(logic [DATA_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_top(v);
    @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_byte();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Favor positions inside the permuted range, sometimes reach above it
  function automatic logic [DATA_W-1:0] pick_pos(int unsigned n);
    if ($urandom_range(99) < 70) return DATA_W'($urandom_range(n, 0));
    return DATA_W'($urandom_range(MAX_ENTRIES_DEF - 1, 0));
  endfunction

  // One setting: mostly whole keys followed by reads, some broken keys and noise
  task automatic run_phase(logic [DATA_W-1:0] top, int budget, int idle);
    int sent;
    int roll;
    int cnt;
    set_top(top);
    idle_pct = idle;
    sent = 0;
    while (sent < budget) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        for (int k = 0; k <= top; k++) load_byte(pick_byte());
        sent += top + 1;
        cnt = $urandom_range(5, 1);
        repeat (cnt) read_entry(pick_pos(top));
        sent += cnt;
      end else if (roll < 90 && top > 0) begin
        cnt = $urandom_range(top, 1);
        repeat (cnt) load_byte(pick_byte());
        read_entry(pick_pos(top));
        sent += cnt + 1;
      end else begin
        push_item(1'($urandom_range(1)), pick_byte(), DATA_W'($urandom));
        sent++;
      end
    end
    idle_pct = 0;
  endtask

  // Hard stop on a hung run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0] tops [12];
    int budget;
    tops = '{8'd3, 8'd0, 8'd9, 8'd1, 8'd31, 8'd2, 8'd255, 8'd16, 8'd7, 8'd4, 8'd5, 8'd12};

    // Hold reset low, then release it
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reads before any key: identity, not complete
    read_entry(8'd0);
    read_entry(8'd255);

    // Single-byte key completes with no swap; read above the range
    set_top(8'd0);
    load_byte(8'hAA);
    read_entry(8'd0);
    read_entry(8'd200);

    // Two-byte key with the largest sum
    set_top(8'd1);
    load_byte(8'hFF);
    load_byte(8'hFF);
    read_entry(8'd0);
    read_entry(8'd1);

    // Partial key reads identity, then a register write drops it
    set_top(8'd3);
    load_byte(8'h12);
    load_byte(8'h34);
    read_entry(8'd0);
    set_top(8'd3);
    load_byte(8'h00);
    load_byte(8'hFF);
    load_byte(8'h80);
    load_byte(8'h01);
    for (int p = 0; p < 4; p++) read_entry(DATA_W'(p));

    // First byte of a new key resets the store and the flag
    load_byte(8'h55);
    read_entry(8'd2);

    // Random phases across settings and sender idling
    foreach (tops[k]) begin
      budget = (tops[k] > 20) ? int'(tops[k]) * 3 / 4 + 8 : 10;
      case (k % 3)
        0: run_phase(tops[k], budget, 0);
        1: run_phase(tops[k], budget, 65);
        default: run_phase(tops[k], budget, 30);
      endcase
    end

    // Wait for the last results, then let a shuffle run out
    start <= 1'b0;
    for (int w = 0; w < 5000 && sb.pending.size() != 0; w++) @(posedge clk);
    repeat (16 * sb.span() + 16) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected result beats never arrived", sb.pending.size()));

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
